[src/sobel_edge_magnitude_rgb_defines.svh]
// Assertion macros shared by the Sobel edge magnitude RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SEM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sem: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define SEM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sem: next-cycle check failed");

`endif

[src/sem_pkg.sv]
// Package of the Sobel edge magnitude block: sizes, register indexes and
// the command and status structs between controller and datapath.
// Depends on nothing.
package sem_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int WID_W      = 11;
    localparam int HGT_W      = 13;
    localparam int IROW_W     = 13;
    localparam int OROW_W     = 12;
    localparam int PIX_W      = 8;
    localparam int NCH        = 3;
    localparam int GRAD_W     = 11;
    localparam int SUM_W      = 21;
    localparam int ROOT_W     = 8;
    localparam int BIT_W      = $clog2(ROOT_W);
    localparam int ADDR_W     = 3;
    localparam int SAT_LIM    = 65281;

    // Register index, taken from paddr bit 2.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef logic [NCH*PIX_W-1:0] t_pix;

    typedef struct packed {
        logic             clear;
        logic [COL_W-1:0] clear_addr;
        logic             take;
        logic             shift;
        logic             grad;
        logic             square;
        logic             root_step;
        logic [BIT_W-1:0] root_bit;
        logic             load;
        logic             restart;
    } t_cmd;

    typedef struct packed {
        logic emit;
    } t_sts;

endpackage

[src/sem_if.sv]
// Request and result channel interfaces of the Sobel edge magnitude block.
// Depends on sem_pkg.
interface sem_req_if import sem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [PIX_W-1:0] in_blue;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_red;

    modport source (output valid, req_type, in_blue, in_green, in_red, input ready);
    modport sink   (input valid, req_type, in_blue, in_green, in_red, output ready);
endinterface

interface sem_res_if import sem_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_blue;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_red;
    logic             frame_end;

    modport source (output valid, out_blue, out_green, out_red, frame_end, input ready);
    modport sink   (input valid, out_blue, out_green, out_red, frame_end, output ready);
endinterface

[src/sem_dpath.sv]
// Datapath of the Sobel edge magnitude block: line stores, window,
// position counters, gradients, squares and the shared square root step.
// Depends on sem_pkg.
module sem_dpath import sem_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [WID_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    input  logic             i_req_type,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_red,
    output logic [PIX_W-1:0] o_blue,
    output logic [PIX_W-1:0] o_green,
    output logic [PIX_W-1:0] o_red,
    output logic             o_frame_end
);

    t_pix r_mem_up  [MAX_WIDTH];
    t_pix r_mem_mid [MAX_WIDTH];
    t_pix r_rd_up;
    t_pix r_rd_mid;
    t_pix r_pix;
    t_pix r_win [3][3];

    logic [COL_W-1:0]  r_in_col;
    logic [IROW_W-1:0] r_in_row;
    logic [COL_W-1:0]  r_out_col;
    logic [OROW_W-1:0] r_out_row;
    logic r_keep_top, r_keep_bot, r_keep_left, r_keep_right;

    logic signed [GRAD_W-1:0] r_gx [NCH];
    logic signed [GRAD_W-1:0] r_gy [NCH];
    logic signed [GRAD_W-1:0] w_gx [NCH];
    logic signed [GRAD_W-1:0] w_gy [NCH];
    logic [SUM_W-1:0]         r_sum  [NCH];
    logic [ROOT_W-1:0]        r_root [NCH];
    logic [ROOT_W-1:0]        w_trial [NCH];
    logic [ROOT_W-1:0]        w_round [NCH];
    logic [PIX_W-1:0]         r_out_pix [NCH];
    logic                     r_fe;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic [COL_W-1:0] col_eff;
    logic [WID_W-1:0] n_col;
    logic             w_keep [3][3];
    logic             w_fe;
    logic [COL_W-1:0] n_out_col;

    always_comb begin
        if (i_width == '0) begin
            w_eff = WID_W'(1);
        end else if (i_width > WID_W'(MAX_WIDTH)) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = i_width;
        end
        if (i_height == '0) begin
            h_eff = HGT_W'(1);
        end else if (i_height > HGT_W'(MAX_HEIGHT)) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = i_height;
        end
    end

    assign col_eff = (WID_W'(r_in_col) >= w_eff) ? '0 : r_in_col;
    assign n_col   = WID_W'(col_eff) + WID_W'(1);

    assign o_sts.emit = (r_in_row >= IROW_W'(2)) ||
                        ((r_in_row == IROW_W'(1)) && (col_eff != '0));

    // Line stores: one write and one registered read per cycle each.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mem_up[i_cmd.clear_addr]  <= '0;
            r_mem_mid[i_cmd.clear_addr] <= '0;
        end else if (i_cmd.shift) begin
            r_mem_up[col_eff]  <= r_rd_mid;
            r_mem_mid[col_eff] <= r_pix;
        end
        r_rd_up  <= r_mem_up[col_eff];
        r_rd_mid <= r_mem_mid[col_eff];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_pix <= i_req_type ? '0 : {i_red, i_green, i_blue};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_win[r][c] <= '0;
                end
            end
        end else if (i_cmd.shift) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r][0] <= r_win[r][1];
                r_win[r][1] <= r_win[r][2];
            end
            r_win[0][2] <= r_rd_up;
            r_win[1][2] <= r_rd_mid;
            r_win[2][2] <= r_pix;
        end
    end

    assign w_fe = ((HGT_W'(r_out_row) + HGT_W'(1)) >= h_eff) &&
                  ((WID_W'(r_out_col) + WID_W'(1)) >= w_eff);
    assign n_out_col = r_out_col + COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (i_cmd.shift) begin
            if (n_col >= w_eff) begin
                r_in_col <= '0;
                if (r_in_row != '1) begin
                    r_in_row <= r_in_row + IROW_W'(1);
                end
            end else begin
                r_in_col <= n_col[COL_W-1:0];
            end
        end else if (i_cmd.load) begin
            if (w_fe) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else if ((WID_W'(r_out_col) + WID_W'(1)) >= w_eff) begin
                r_out_col <= '0;
                r_out_row <= r_out_row + OROW_W'(1);
            end else begin
                r_out_col <= n_out_col;
            end
        end
    end

    // Border mask for the result about to be computed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.shift) begin
            r_keep_top   <= (r_out_row != '0);
            r_keep_bot   <= (HGT_W'(r_out_row) + HGT_W'(1)) < h_eff;
            r_keep_left  <= (r_out_col != '0);
            r_keep_right <= (WID_W'(r_out_col) + WID_W'(1)) < w_eff;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_keep[r][c] = (r != 0 || r_keep_top) && (r != 2 || r_keep_bot) &&
                               (c != 0 || r_keep_left) && (c != 2 || r_keep_right);
            end
        end
    end

    always_comb begin
        logic [PIX_W-1:0] p [3][3];
        logic [9:0] pos_x, neg_x, pos_y, neg_y;
        for (int ch = 0; ch < NCH; ch++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    p[r][c] = w_keep[r][c] ? r_win[r][c][ch*PIX_W +: PIX_W] : '0;
                end
            end
            pos_x = 10'(p[0][2]) + 10'({p[1][2], 1'b0}) + 10'(p[2][2]);
            neg_x = 10'(p[0][0]) + 10'({p[1][0], 1'b0}) + 10'(p[2][0]);
            pos_y = 10'(p[2][0]) + 10'({p[2][1], 1'b0}) + 10'(p[2][2]);
            neg_y = 10'(p[0][0]) + 10'({p[0][1], 1'b0}) + 10'(p[0][2]);
            w_gx[ch] = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
            w_gy[ch] = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
        end
    end

    always_comb begin
        logic [2*ROOT_W:0] lim;
        logic [ROOT_W:0]   up;
        for (int ch = 0; ch < NCH; ch++) begin
            w_trial[ch] = r_root[ch] | (ROOT_W'(1) << i_cmd.root_bit);
            lim = (2*ROOT_W+1)'(r_root[ch]) * (2*ROOT_W+1)'(r_root[ch]) +
                  (2*ROOT_W+1)'(r_root[ch]);
            up  = (ROOT_W+1)'(r_root[ch]) + (ROOT_W+1)'(r_sum[ch] > SUM_W'(lim));
            if (r_sum[ch] >= SUM_W'(SAT_LIM) || up[ROOT_W]) begin
                w_round[ch] = '1;
            end else begin
                w_round[ch] = up[ROOT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [2*GRAD_W-1:0] sq_x, sq_y;
        logic [2*ROOT_W-1:0]        tsq;
        for (int ch = 0; ch < NCH; ch++) begin
            if (i_cmd.grad) begin
                r_gx[ch] <= w_gx[ch];
                r_gy[ch] <= w_gy[ch];
            end
            if (i_cmd.square) begin
                sq_x = r_gx[ch] * r_gx[ch];
                sq_y = r_gy[ch] * r_gy[ch];
                r_sum[ch]  <= SUM_W'($unsigned(sq_x)) + SUM_W'($unsigned(sq_y));
                r_root[ch] <= '0;
            end else if (i_cmd.root_step) begin
                tsq = w_trial[ch] * w_trial[ch];
                if (SUM_W'(tsq) <= r_sum[ch]) begin
                    r_root[ch] <= w_trial[ch];
                end
            end
            if (i_cmd.load) begin
                r_out_pix[ch] <= w_round[ch];
            end
        end
        if (i_cmd.load) begin
            r_fe <= w_fe;
        end
    end

    assign o_blue      = r_out_pix[0];
    assign o_green     = r_out_pix[1];
    assign o_red       = r_out_pix[2];
    assign o_frame_end = r_fe;

endmodule

[src/sem_ctrl.sv]
// Controller of the Sobel edge magnitude block: clearing pass, request
// sequencing, square root steps and the result valid flag.
// Depends on sem_pkg and the assertion macros header.
`include "sobel_edge_magnitude_rgb_defines.svh"
module sem_ctrl import sem_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  logic i_cfg_wr,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SHIFT,
        ST_GRAD,
        ST_SQUARE,
        ST_ROOT,
        ST_LOAD
    } t_state;

    t_state           r_state;
    logic [COL_W-1:0] r_clr_addr;
    logic [BIT_W-1:0] r_bit;
    logic             r_out_valid;
    logic             w_accept;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = o_in_ready && i_in_valid;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd            = '0;
        o_cmd.clear      = (r_state == ST_CLEAR);
        o_cmd.clear_addr = r_clr_addr;
        o_cmd.take       = w_accept;
        o_cmd.shift      = (r_state == ST_SHIFT);
        o_cmd.grad       = (r_state == ST_GRAD);
        o_cmd.square     = (r_state == ST_SQUARE);
        o_cmd.root_step  = (r_state == ST_ROOT);
        o_cmd.root_bit   = r_bit;
        o_cmd.load       = (r_state == ST_LOAD) && (!r_out_valid || i_out_ready);
        o_cmd.restart    = i_cfg_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_bit       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_CLEAR: begin
                    if (r_clr_addr == COL_W'(MAX_WIDTH - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + COL_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_SHIFT;
                    end
                end
                ST_SHIFT: begin
                    r_state <= i_sts.emit ? ST_GRAD : ST_IDLE;
                end
                ST_GRAD: begin
                    r_state <= ST_SQUARE;
                end
                ST_SQUARE: begin
                    r_bit   <= BIT_W'(ROOT_W - 1);
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (r_bit == '0) begin
                        r_state <= ST_LOAD;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                ST_LOAD: begin
                    if (o_cmd.load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (o_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `SEM_ASSERT_IMP(a_load_free, i_clk, i_rst_n, o_cmd.load, !r_out_valid || i_out_ready)
    `SEM_ASSERT_NEXT(a_accept_shift, i_clk, i_rst_n, w_accept, r_state == ST_SHIFT)
    `SEM_ASSERT_NEXT(a_root_end, i_clk, i_rst_n, (r_state == ST_ROOT) && (r_bit == '0), r_state == ST_LOAD)

endmodule

[src/sobel_edge_magnitude_rgb.sv]
// Sobel 3x3 edge magnitude on an RGB stream. Pixels of a frame arrive in raster
// order on the request channel; for each pixel one result gives, per colour, the
// rounded magnitude sqrt(Gx*Gx + Gy*Gy) saturated at 255, with pixels outside the
// frame taken as zero, and frame_end marks the last result of the frame. A result
// lags its pixel by one row and one pixel, so after the last pixel the user sends
// image_width+1 flush requests (req_type = 1) to push the rest out. After reset
// the two line stores are cleared address by address, during which no request is
// accepted. A request that yields no result goes through the accept and then the
// line store and window update. A request that yields a result goes through the
// accept, the update, the gradients, the squares, the square root, which finds
// one bit of the root per cycle, and the step that rounds and loads the output
// register; it waits longer in that last step only while that register still holds
// a result the sink has not taken. Writing image_width (address 0) or
// image_height (address 4) restarts the frame; widths and heights out of range
// are clamped to 1..1024 and 1..4096.
// Depends on sem_pkg, sem_if, sem_ctrl and sem_dpath.
module sobel_edge_magnitude_rgb import sem_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sem_req_if.sink           i_req,
    sem_res_if.source         o_res,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [31:0]       i_pwdata,
    output logic [31:0]       o_prdata,
    output logic              o_pready
);

    logic [WID_W-1:0] r_width;
    logic [HGT_W-1:0] r_height;
    logic             w_cfg_wr;
    t_cmd             w_cmd;
    t_sts             w_sts;

    // Registers are written in the access phase; pready is always high.
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(1024);
            r_height <= HGT_W'(1024);
        end else if (w_cfg_wr) begin
            case (i_paddr[2])
                REG_WIDTH:  r_width  <= i_pwdata[WID_W-1:0];
                REG_HEIGHT: r_height <= i_pwdata[HGT_W-1:0];
                default:    r_width  <= r_width;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[2])
            REG_WIDTH:  o_prdata = 32'(r_width);
            REG_HEIGHT: o_prdata = 32'(r_height);
            default:    o_prdata = '0;
        endcase
    end

    // The controller sequences each request; the datapath does the work.
    sem_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_cfg_wr    (w_cfg_wr),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    sem_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_req_type  (i_req.req_type),
        .i_blue      (i_req.in_blue),
        .i_green     (i_req.in_green),
        .i_red       (i_req.in_red),
        .o_blue      (o_res.out_blue),
        .o_green     (o_res.out_green),
        .o_red       (o_res.out_red),
        .o_frame_end (o_res.frame_end)
    );

endmodule

[test/tb_sobel_edge_magnitude_rgb.sv]
// Self-checking testbench of the Sobel edge magnitude block: random and directed
// frames over the request channel, APB writes of the frame size, a scoreboard.
// Depends on sem_pkg, sem_if and the sobel_edge_magnitude_rgb RTL.

// Expected output of one pixel of the frame.
typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
} edge_pix_t;

// Tracks the line stores, the window and the frame position, and keeps the
// edge magnitudes that the block still owes.
class edge_scoreboard;
    bit [23:0]  upper_line [sem_pkg::MAX_WIDTH];
    bit [23:0]  middle_line [sem_pkg::MAX_WIDTH];
    bit [23:0]  win [3][3];
    bit [10:0]  width_reg;
    bit [12:0]  height_reg;
    int         in_col, in_row, out_col, out_row;
    edge_pix_t  owed [$];
    int         errors, requests, results;

    function void reset_state();
        foreach (upper_line[i]) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        foreach (win[r, c]) win[r][c] = '0;
        width_reg = 11'd1024;
        height_reg = 13'd1024;
        restart();
    endfunction

    function void restart();
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function void set_register(logic index, logic [31:0] value);
        if (index == sem_pkg::REG_WIDTH) width_reg = value[10:0];
        else height_reg = value[12:0];
        restart();
    endfunction

    function int frame_width();
        if (width_reg == 0) return 1;
        if (width_reg > sem_pkg::MAX_WIDTH) return sem_pkg::MAX_WIDTH;
        return width_reg;
    endfunction

    function int frame_height();
        if (height_reg == 0) return 1;
        if (height_reg > sem_pkg::MAX_HEIGHT) return sem_pkg::MAX_HEIGHT;
        return height_reg;
    endfunction

    // Rounded square root, saturated at 255.
    function logic [7:0] rounded_root(int sum);
        int n;
        n = 0;
        if (sum >= sem_pkg::SAT_LIM) return 8'd255;
        while ((n + 1) * (n + 1) <= sum) n++;
        if (sum > n * n + n) n++;
        return (n > 255) ? 8'd255 : n[7:0];
    endfunction

    function logic [7:0] gradient_mag(bit keep [3][3], int sh);
        int gx, gy, p, kx, ky;
        gx = 0;
        gy = 0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                if (keep[r][c]) begin
                    p = win[r][c][sh +: 8];
                    kx = (c - 1) * ((r == 1) ? 2 : 1);
                    ky = (r - 1) * ((c == 1) ? 2 : 1);
                    gx += kx * p;
                    gy += ky * p;
                end
            end
        end
        return rounded_root(gx * gx + gy * gy);
    endfunction

    function void note_request(logic flush, logic [7:0] b, logic [7:0] g,
                               logic [7:0] r);
        int w, h, col;
        bit [23:0] v, up, md;
        bit emit;
        bit keep [3][3];
        edge_pix_t e;
        w = frame_width();
        h = frame_height();
        v = flush ? 24'd0 : {r, g, b};
        requests++;
        col = (in_col >= w) ? 0 : in_col;
        up = upper_line[col];
        md = middle_line[col];
        upper_line[col] = md;
        middle_line[col] = v;
        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        win[0][2] = up;
        win[1][2] = md;
        win[2][2] = v;
        emit = (in_row >= 2) || (in_row == 1 && col >= 1);
        col++;
        if (col >= w) begin
            col = 0;
            if (in_row < 8191) in_row++;
        end
        in_col = col;
        if (!emit) return;
        // Neighbours outside the frame count as zero.
        for (int rr = 0; rr < 3; rr++) begin
            for (int cc = 0; cc < 3; cc++) begin
                keep[rr][cc] = !((rr == 0 && out_row == 0) ||
                                 (rr == 2 && out_row + 1 >= h) ||
                                 (cc == 0 && out_col == 0) ||
                                 (cc == 2 && out_col + 1 >= w));
            end
        end
        e.blue = gradient_mag(keep, 0);
        e.green = gradient_mag(keep, 8);
        e.red = gradient_mag(keep, 16);
        e.last = (out_row + 1 >= h) && (out_col + 1 >= w);
        owed.push_back(e);
        if (e.last) begin
            restart();
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
    endfunction

    function void check_result(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                               logic fe);
        edge_pix_t e;
        results++;
        if (owed.size() == 0) begin
            $display("%0t: unexpected result b=%0d g=%0d r=%0d fe=%0b",
                     $time, b, g, r, fe);
            errors++;
            return;
        end
        e = owed.pop_front();
        if (b !== e.blue) begin
            $display("%0t: out_blue expected %0d actual %0d", $time, e.blue, b);
            errors++;
        end
        if (g !== e.green) begin
            $display("%0t: out_green expected %0d actual %0d", $time, e.green, g);
            errors++;
        end
        if (r !== e.red) begin
            $display("%0t: out_red expected %0d actual %0d", $time, e.red, r);
            errors++;
        end
        if (fe !== e.last) begin
            $display("%0t: frame_end expected %0b actual %0b", $time, e.last, fe);
            errors++;
        end
    endfunction
endclass

module tb_sobel_edge_magnitude_rgb;
    import sem_pkg::*;

    // Idling modes: none, sender idle, receiver stalling, both.
    localparam int IDLE_NONE = 0;
    localparam int IDLE_SEND = 1;
    localparam int IDLE_RECV = 2;
    localparam int IDLE_BOTH = 3;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int RANDOM_REQUESTS = 1850;
    // A request that yields no result may still be in flight once the last owed
    // result is out; this margin covers it.
    localparam int SETTLE_CYCLES = 20;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_psel;
    logic              i_penable;
    logic              i_pwrite;
    logic [ADDR_W-1:0] i_paddr;
    logic [31:0]       i_pwdata;
    logic [31:0]       o_prdata;
    logic              o_pready;

    sem_req_if req_bus ();
    sem_res_if res_bus ();

    sobel_edge_magnitude_rgb dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_bus),
        .o_res     (res_bus),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    edge_scoreboard sb;
    int idle_mode;
    int cycles;
    int frames;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb_sobel_edge_magnitude_rgb: done, errors");
            $finish;
        end
    end

    // The result side stalls according to the current idling mode.
    always @(negedge i_clk) begin
        if (idle_mode == IDLE_RECV) res_bus.ready = ($urandom_range(99) >= 81);
        else if (idle_mode == IDLE_BOTH) res_bus.ready = ($urandom_range(99) >= 28);
        else res_bus.ready = 1'b1;
    end

    // Every result accepted at a rising edge is checked against the oldest
    // owed magnitude.
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready)
            sb.check_result(res_bus.out_blue, res_bus.out_green, res_bus.out_red,
                            res_bus.frame_end);
    end

    // Sends one request. Called at a falling edge and returns at one; valid
    // is left high so back-to-back requests never lower and raise it at once.
    task automatic send_request(logic flush, logic [7:0] b, logic [7:0] g,
                                logic [7:0] r);
        int idle_pct;
        idle_pct = (idle_mode == IDLE_SEND) ? 81 : (idle_mode == IDLE_BOTH) ? 28 : 0;
        while ($urandom_range(99) < idle_pct) begin
            req_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        req_bus.valid = 1'b1;
        req_bus.req_type = flush;
        req_bus.in_blue = b;
        req_bus.in_green = g;
        req_bus.in_red = r;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        sb.note_request(flush, b, g, r);
        @(negedge i_clk);
    endtask

    // A random pixel leaning towards the extremes of each channel.
    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(99);
        if (sel < 15) return 8'd0;
        if (sel < 30) return 8'd255;
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random();
        send_request($urandom_range(99) < 8, pick_level(), pick_level(), pick_level());
    endtask

    // Holds the requests back until every owed result has come out, so the
    // block is idle before the registers are touched.
    task automatic wait_idle();
        req_bus.valid = 1'b0;
        while (sb.owed.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: setup phase, then access phase; pready is sampled at the edge.
    task automatic write_register(logic index, logic [31:0] value);
        i_psel = 1'b1;
        i_penable = 1'b0;
        i_pwrite = 1'b1;
        i_paddr = {index, 2'b00};
        i_pwdata = value;
        @(negedge i_clk);
        i_penable = 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        sb.set_register(index, value);
        @(negedge i_clk);
        i_psel = 1'b0;
        i_penable = 1'b0;
    endtask

    // Frame size with random junk above the register fields.
    task automatic set_frame(int w, int h);
        logic [31:0] junk;
        wait_idle();
        junk = $urandom;
        write_register(REG_WIDTH, {junk[31:11], w[10:0]});
        junk = $urandom;
        write_register(REG_HEIGHT, {junk[31:13], h[12:0]});
    endtask

    // One whole frame followed by width+1 trailing requests, which are a
    // mix of flushes and pixels past the frame.
    task automatic send_frame(int w, int h);
        int ew, eh;
        set_frame(w, h);
        ew = sb.frame_width();
        eh = sb.frame_height();
        repeat (ew * eh) send_random();
        repeat (ew + 1) send_request(1'($urandom_range(1)), pick_level(), pick_level(),
                                     pick_level());
        frames++;
    endtask

    initial begin
        int start_count, w, h, sel;
        sb = new();
        sb.reset_state();
        idle_mode = IDLE_NONE;
        frames = 0;
        i_rst_n = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        req_bus.valid = 1'b0;
        req_bus.req_type = 1'b0;
        req_bus.in_blue = '0;
        req_bus.in_green = '0;
        req_bus.in_red = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. A 3x2 frame of extreme pixels with a flush inside the
        // frame, then a trailing mix of flushes and pixels past the frame.
        set_frame(3, 2);
        send_request(1'b0, 8'd255, 8'd255, 8'd255);
        send_request(1'b0, 8'd0, 8'd0, 8'd0);
        send_request(1'b0, 8'd255, 8'd0, 8'd255);
        send_request(1'b1, 8'd255, 8'd255, 8'd255);
        send_request(1'b0, 8'd255, 8'd255, 8'd0);
        send_request(1'b0, 8'd0, 8'd255, 8'd255);
        send_request(1'b1, 8'd0, 8'd0, 8'd0);
        send_request(1'b0, 8'd255, 8'd255, 8'd255);
        send_request(1'b1, 8'd255, 8'd0, 8'd0);
        send_request(1'b0, 8'd17, 8'd200, 8'd99);
        // Zero width and height act as a single pixel frame.
        set_frame(0, 0);
        send_request(1'b0, 8'd255, 8'd255, 8'd255);
        send_request(1'b1, 8'd0, 8'd0, 8'd0);
        send_request(1'b1, 8'd0, 8'd0, 8'd0);
        // Oversized values clamp to the maximum; a few requests of a partial
        // frame only, since a full frame of that size would take far too long.
        set_frame(2047, 8191);
        repeat (5) send_random();
        set_frame(MAX_WIDTH, MAX_HEIGHT);
        repeat (3) send_random();
        // Single row and single column frames.
        send_frame(4, 1);
        send_frame(1, 3);

        // Random frames, rotating through the idling modes; one in twelve is
        // broken off part way through by the next register write.
        start_count = sb.requests;
        while (sb.requests - start_count < RANDOM_REQUESTS) begin
            idle_mode = (frames % 5 == 4) ? $urandom_range(3) : frames % 4;
            sel = $urandom_range(99);
            w = (sel < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);
            h = $urandom_range(1, 6);
            if ($urandom_range(11) == 0) begin
                set_frame(w, h);
                repeat ($urandom_range(2 * w)) send_random();
                frames++;
            end else begin
                send_frame(w, h);
            end
        end

        wait_idle();
        repeat (40) @(negedge i_clk);
        $display("Covered %0d frames (clamped, partial and whole) with %0d requests",
                 frames, sb.requests);
        $display("and %0d edge results checked under four idling modes.", sb.results);
        if (sb.errors == 0 && sb.owed.size() == 0) begin
            $display("tb_sobel_edge_magnitude_rgb: done, clean");
        end else begin
            $display("tb_sobel_edge_magnitude_rgb: done, errors");
        end
        $finish;
    end
endmodule
